@@ rtl/sacl_pkg.sv @@
package sacl_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_BITS    = 32;

    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int SET_IDX_BITS = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_BITS     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_BITS    = WAY_BITS;
    localparam int TAG_BITS     = ADDR_BITS;
    localparam int CNT_BITS     = 32;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;
    localparam int SB_CFG_BITS   = 3;
    localparam int WAYS_CFG_BITS = 4;
    localparam int BB_CFG_BITS   = 5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_BITS = 2'd2;

    localparam logic [SB_CFG_BITS-1:0]   RST_SET_BITS   = 3'd4;
    localparam logic [WAYS_CFG_BITS-1:0] RST_WAYS       = 4'd1;
    localparam logic [BB_CFG_BITS-1:0]   RST_BLOCK_BITS = 5'd4;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    localparam int OUT_USED = 2 + 1 + 1 + 3 * CNT_BITS;
    localparam int OUT_BITS = ((OUT_USED + 7) / 8) * 8;
    localparam int OUT_PAD  = OUT_BITS - OUT_USED;

    typedef enum logic [1:0] {
        OP_FETCH  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_STORE  = 2'd2,
        OP_MODIFY = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_ACC1,
        S_ACC2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 valid;
        logic [TAG_BITS-1:0]  tag;
        logic [RANK_BITS-1:0] rank;
    } t_line;

    typedef t_line [MAX_WAYS-1:0] t_row;

    typedef struct packed {
        logic load_in;
        logic look;
        logic acc1;
        logic acc2;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_fetch;
        logic is_modify;
        logic out_free;
    } t_sts;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

@@ rtl/sacl_ram.sv @@
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_addr,
    input  logic [WIDTH-1:0]                 i_wdata,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sacl_ctrl.sv @@
module sacl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sacl_pkg::t_sts  i_sts,
    output sacl_pkg::t_cmd  o_cmd
);
    import sacl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = i_sts.is_fetch ? S_DONE : S_ACC1;
            end
            S_ACC1: begin
                n_state = i_sts.is_modify ? S_ACC2 : S_DONE;
            end
            S_ACC2: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
            end
            S_ACC1: begin
                o_cmd.acc1 = 1'b1;
            end
            S_ACC2: begin
                o_cmd.acc2 = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_LOOK))
        else $error("accepted request did not start a lookup");

    a_second_access_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC2) |-> i_sts.is_modify)
        else $error("second access for a non-modify request");

    a_fetch_skips_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && i_sts.is_fetch) |=> (r_state == S_DONE))
        else $error("fetch request touched the tag store");

    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_state == S_IDLE && o_in_ready))
        else $error("no return to idle after result load");

endmodule

@@ rtl/sacl_dp.sv @@
module sacl_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [sacl_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic [1:0]                             i_opcode,
    input  logic [sacl_pkg::ADDR_BITS-1:0]         i_address,
    input  sacl_pkg::t_cmd                         i_cmd,
    output sacl_pkg::t_sts                         o_sts,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [sacl_pkg::OUT_BITS-1:0]          o_out_data
);
    import sacl_pkg::*;

    logic [SB_CFG_BITS-1:0]   r_cfg_set_bits;
    logic [WAYS_CFG_BITS-1:0] r_cfg_ways;
    logic [BB_CFG_BITS-1:0]   r_cfg_block_bits;

    t_opcode               r_op;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [SET_IDX_BITS-1:0] r_set;
    logic [TAG_BITS-1:0]   r_tag;
    t_row                  r_row;
    logic [NUM_SETS-1:0]   r_row_vld;

    logic [1:0]            r_hits;
    logic                  r_missed;
    logic                  r_evicted;
    logic [CNT_BITS-1:0]   r_hit_total;
    logic [CNT_BITS-1:0]   r_miss_total;
    logic [CNT_BITS-1:0]   r_evict_total;

    logic                  r_out_vld;
    logic [OUT_BITS-1:0]   r_out_data;

    logic [SB_CFG_BITS-1:0]   eff_sb;
    logic [WAYS_CFG_BITS-1:0] eff_nw;
    logic [ADDR_BITS-1:0]     shifted;
    logic [SET_IDX_BITS:0]    set_mask;
    logic [SET_IDX_BITS-1:0]  set_c;
    logic [TAG_BITS-1:0]      tag_c;

    logic                     ram_we;
    logic [SET_IDX_BITS-1:0]  ram_addr;
    t_row                     ram_rdata;

    t_row                     row_in;
    t_row                     row_new;
    logic                     hit_any;
    logic                     inv_any;
    logic                     vic_found;
    logic [WAY_BITS-1:0]      hit_way;
    logic [WAY_BITS-1:0]      inv_way;
    logic [WAY_BITS-1:0]      vic_way;
    logic [RANK_BITS-1:0]     vic_rank;
    logic [WAY_BITS-1:0]      tgt;
    logic [RANK_BITS-1:0]     tgt_rank;
    logic                     is_fill;
    logic                     acc;
    logic                     out_free;

    // effective configuration
    always_comb begin
        eff_sb = (r_cfg_set_bits > SB_CFG_BITS'(MAX_SET_BITS)) ?
                 SB_CFG_BITS'(MAX_SET_BITS) : r_cfg_set_bits;
        priority if (r_cfg_ways == '0) begin
            eff_nw = WAYS_CFG_BITS'(1);
        end else if (r_cfg_ways > WAYS_CFG_BITS'(MAX_WAYS)) begin
            eff_nw = WAYS_CFG_BITS'(MAX_WAYS);
        end else begin
            eff_nw = r_cfg_ways;
        end
    end

    // address split
    always_comb begin
        shifted  = r_addr >> r_cfg_block_bits;
        set_mask = (SET_IDX_BITS+1)'((1 << eff_sb) - 1);
        set_c    = shifted[SET_IDX_BITS-1:0] & set_mask[SET_IDX_BITS-1:0];
        tag_c    = shifted >> eff_sb;
    end

    assign acc      = i_cmd.acc1 | i_cmd.acc2;
    assign ram_we   = acc;
    assign ram_addr = i_cmd.look ? set_c : r_set;

    sacl_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (row_new),
        .o_rdata (ram_rdata)
    );

    // a row never written since reset reads as all ways invalid
    always_comb begin
        if (i_cmd.acc2) begin
            row_in = r_row;
        end else if (r_row_vld[r_set]) begin
            row_in = ram_rdata;
        end else begin
            row_in = '0;
        end
    end

    // lookup and replacement
    always_comb begin
        hit_any   = 1'b0;
        inv_any   = 1'b0;
        vic_found = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        vic_way   = '0;
        vic_rank  = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAYS_CFG_BITS'(w) < eff_nw) begin
                if (!hit_any && row_in[w].valid && row_in[w].tag == r_tag) begin
                    hit_any = 1'b1;
                    hit_way = WAY_BITS'(w);
                end
                if (!inv_any && !row_in[w].valid) begin
                    inv_any = 1'b1;
                    inv_way = WAY_BITS'(w);
                end
                if (!vic_found || row_in[w].rank < vic_rank) begin
                    vic_found = 1'b1;
                    vic_way   = WAY_BITS'(w);
                    vic_rank  = row_in[w].rank;
                end
            end
        end
        is_fill  = !hit_any && inv_any;
        tgt      = hit_any ? hit_way : (inv_any ? inv_way : vic_way);
        tgt_rank = row_in[tgt].rank;
    end

    always_comb begin
        row_new = row_in;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAYS_CFG_BITS'(w) < eff_nw && WAY_BITS'(w) != tgt && row_in[w].valid &&
                (is_fill || row_in[w].rank > tgt_rank) && row_in[w].rank != '0) begin
                row_new[w].rank = row_in[w].rank - 1'b1;
            end
        end
        row_new[tgt].valid = 1'b1;
        row_new[tgt].tag   = r_tag;
        row_new[tgt].rank  = RANK_BITS'(eff_nw - 1'b1);
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_set_bits   <= RST_SET_BITS;
            r_cfg_ways       <= RST_WAYS;
            r_cfg_block_bits <= RST_BLOCK_BITS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SET_BITS:   r_cfg_set_bits   <= i_cfg_data[SB_CFG_BITS-1:0];
                CFG_WAYS:       r_cfg_ways       <= i_cfg_data[WAYS_CFG_BITS-1:0];
                CFG_BLOCK_BITS: r_cfg_block_bits <= i_cfg_data[BB_CFG_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // request and row payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= t_opcode'(i_opcode);
            r_addr <= i_address;
        end
        if (i_cmd.look) begin
            r_set <= set_c;
            r_tag <= tag_c;
        end
        if (acc) begin
            r_row <= row_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (acc) begin
            r_row_vld[r_set] <= 1'b1;
        end
    end

    // per-request outcome
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_hits    <= '0;
            r_missed  <= 1'b0;
            r_evicted <= 1'b0;
        end else if (i_cmd.acc1) begin
            r_hits    <= hit_any ? 2'd1 : 2'd0;
            r_missed  <= !hit_any;
            r_evicted <= !hit_any && !inv_any;
        end else if (i_cmd.acc2 && hit_any) begin
            r_hits    <= r_hits + 2'd1;
        end
    end

    // running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_total   <= '0;
            r_miss_total  <= '0;
            r_evict_total <= '0;
        end else if (acc) begin
            if (hit_any) begin
                r_hit_total <= sat_inc(r_hit_total);
            end else begin
                r_miss_total <= sat_inc(r_miss_total);
                if (!inv_any) r_evict_total <= sat_inc(r_evict_total);
            end
        end
    end

    // output register
    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {{OUT_PAD{1'b0}}, r_evict_total, r_miss_total, r_hit_total,
                           r_evicted, r_missed, r_hits};
        end
    end

    assign o_sts.is_fetch  = (r_op == OP_FETCH);
    assign o_sts.is_modify = (r_op == OP_MODIFY);
    assign o_sts.out_free  = out_free;
    assign o_out_valid     = r_out_vld;
    assign o_out_data      = r_out_data;

endmodule

@@ rtl/set_assoc_cache_lru_tags_top.sv @@
// Channel   Dir  Signals                                Contents
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready        tuser: opcode; tdata: address
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready        tdata: outcome and running totals
// cfg       in   i_cfg_valid/o_cfg_ready                i_cfg_index, i_cfg_data
//
// A request passes idle, lookup and done; a load or store adds an access and a
// modify a second, each a read-modify-write of one set row in the single-port tag RAM.
// A new request is taken only in idle; a result waits in the output register,
// and the next result holds until that one is taken.
// Reset loads the default configuration and clears the totals and one valid flag
// per set row at once; no clearing pass. Configuration writes are always ready.
module set_assoc_cache_lru_tags_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [1:0]                          i_s_axis_tuser,  // [1:0] opcode
    input  logic [sacl_pkg::ADDR_BITS-1:0]      i_s_axis_tdata,  // [31:0] address
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [1:0] hit_count, [2] missed, [3] evicted, [35:4] total_hits,
    // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
    output logic [sacl_pkg::OUT_BITS-1:0]       o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import sacl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sacl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_opcode    (i_s_axis_tuser),
        .i_address   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

@@ test/set_assoc_cache_lru_tags_top_test.sv @@
module set_assoc_cache_lru_tags_top_test;
    import sacl_pkg::*;

    localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONE = 2'd3;
    localparam int NUM_DIR = 32;
    localparam int NUM_PHASES = 8;
    localparam int ACCESSES_PER_PHASE = 75;

    typedef struct packed {
        logic [1:0]          hit_count;
        logic                missed;
        logic                evicted;
        logic [CNT_BITS-1:0] total_hits;
        logic [CNT_BITS-1:0] total_misses;
        logic [CNT_BITS-1:0] total_evictions;
    } t_result;

    typedef struct packed {
        logic                     is_cfg;
        logic [CFG_IDX_BITS-1:0]  cfg_index;
        logic [CFG_DATA_BITS-1:0] cfg_data;
        t_opcode                  op;
        logic [ADDR_BITS-1:0]     addr;
        logic                     has_exp;
        t_result                  exp;
    } t_stim;

    typedef enum logic [1:0] {ACC_HIT, ACC_FILL, ACC_EVICT} t_access_kind;

    localparam t_result NO_RESULT = '0;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [1:0]                i_s_axis_tuser;
    logic [ADDR_BITS-1:0]      i_s_axis_tdata;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]       o_m_axis_tdata;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    // predictor state
    logic [SB_CFG_BITS-1:0]    cfg_set_bits;
    logic [WAYS_CFG_BITS-1:0]  cfg_ways;
    logic [BB_CFG_BITS-1:0]    cfg_block_bits;
    logic                      way_valid [NUM_LINES];
    logic [TAG_BITS-1:0]       way_tag   [NUM_LINES];
    logic [2:0]                way_rank  [NUM_LINES];
    logic [CNT_BITS-1:0]       hit_total;
    logic [CNT_BITS-1:0]       miss_total;
    logic [CNT_BITS-1:0]       evict_total;

    t_result pending_outcomes [$];
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      rx_hold = 0;
    logic [ADDR_BITS-1:0] addr_pool [16];

    t_stim dir_rows [NUM_DIR] = '{
        '{1'b0, CFG_SET_BITS, 5'd0, OP_FETCH, 32'h0000_0000, 1'b1,
          '{2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD, 32'h0000_0000, 1'b1,
          '{2'd0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd0}},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD, 32'h0000_0000, 1'b1,
          '{2'd1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_MODIFY, 32'h0000_0000, 1'b1,
          '{2'd2, 1'b0, 1'b0, 32'd3, 32'd1, 32'd0}},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_STORE, 32'hFFFF_FFFF, 1'b1,
          '{2'd0, 1'b1, 1'b0, 32'd3, 32'd2, 32'd0}},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD, 32'h0000_0100, 1'b1,
          '{2'd0, 1'b1, 1'b1, 32'd3, 32'd3, 32'd1}},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_MODIFY, 32'h0000_0200, 1'b1,
          '{2'd1, 1'b1, 1'b1, 32'd4, 32'd4, 32'd2}},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_FETCH, 32'hFFFF_FFFF, 1'b1,
          '{2'd0, 1'b0, 1'b0, 32'd4, 32'd4, 32'd2}},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_STORE, 32'hFFFF_FFF0, 1'b1,
          '{2'd1, 1'b0, 1'b0, 32'd5, 32'd4, 32'd2}},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_MODIFY, 32'h0000_0010, 1'b1,
          '{2'd1, 1'b1, 1'b0, 32'd6, 32'd5, 32'd2}},
        // four ways in one set, old lines kept across the change
        '{1'b1, CFG_WAYS,       5'd4,  OP_FETCH, 32'h0, 1'b0, NO_RESULT},
        '{1'b1, CFG_SET_BITS,   5'd0,  OP_FETCH, 32'h0, 1'b0, NO_RESULT},
        '{1'b1, CFG_BLOCK_BITS, 5'd0,  OP_FETCH, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD,   32'h0000_0001, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD,   32'h0000_0002, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_STORE,  32'h0000_0003, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD,   32'h0000_0004, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD,   32'h0000_0001, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD,   32'h0000_0005, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_MODIFY, 32'h0000_0002, 1'b0, NO_RESULT},
        // out-of-range set_bits and ways, widest offset
        '{1'b1, CFG_SET_BITS,   5'd7,  OP_FETCH, 32'h0, 1'b0, NO_RESULT},
        '{1'b1, CFG_WAYS,       5'd15, OP_FETCH, 32'h0, 1'b0, NO_RESULT},
        '{1'b1, CFG_BLOCK_BITS, 5'd31, OP_FETCH, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD,   32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_MODIFY, 32'h8000_0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD,   32'h7FFF_FFFF, 1'b0, NO_RESULT},
        // zero ways, a sixteen-bit offset, write to an unused index
        '{1'b1, CFG_WAYS,       5'd0,  OP_FETCH, 32'h0, 1'b0, NO_RESULT},
        '{1'b1, CFG_BLOCK_BITS, 5'd16, OP_FETCH, 32'h0, 1'b0, NO_RESULT},
        '{1'b1, CFG_NONE,       5'd31, OP_FETCH, 32'h0, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_LOAD,   32'h1234_5678, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_FETCH,  32'h0000_0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_SET_BITS, 5'd0, OP_STORE,  32'hFFFF_0000, 1'b0, NO_RESULT}
    };

    set_assoc_cache_lru_tags_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Move 'mru' to the top; valid lines ranked above 'below' drop one.
    function automatic void make_recent(int base, int nw, int mru, int below);
        for (int w = 0; w < nw; w++) begin
            if (w != mru && way_valid[base + w] &&
                int'(way_rank[base + w]) > below && way_rank[base + w] != 3'd0)
                way_rank[base + w] = way_rank[base + w] - 3'd1;
        end
        way_rank[base + mru] = 3'(nw - 1);
    endfunction

    function automatic t_access_kind lookup_and_fill(input logic [ADDR_BITS-1:0] addr);
        int sb, nw, base, victim;
        logic [63:0] shifted;
        logic [TAG_BITS-1:0] tag;
        sb = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
        nw = (cfg_ways == 0) ? 1 : (cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways);
        shifted = {32'b0, addr} >> cfg_block_bits;
        base = int'(shifted & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
        tag = TAG_BITS'(shifted >> sb);
        for (int w = 0; w < nw; w++) begin
            if (way_valid[base + w] && way_tag[base + w] == tag) begin
                if (hit_total != CNT_MAX) hit_total = hit_total + 1;
                make_recent(base, nw, w, int'(way_rank[base + w]));
                return ACC_HIT;
            end
        end
        if (miss_total != CNT_MAX) miss_total = miss_total + 1;
        for (int w = 0; w < nw; w++) begin
            if (!way_valid[base + w]) begin
                way_valid[base + w] = 1'b1;
                way_tag[base + w] = tag;
                way_rank[base + w] = 3'd0;
                make_recent(base, nw, w, -1);
                return ACC_FILL;
            end
        end
        victim = 0;
        for (int w = 1; w < nw; w++)
            if (way_rank[base + w] < way_rank[base + victim]) victim = w;
        if (evict_total != CNT_MAX) evict_total = evict_total + 1;
        way_tag[base + victim] = tag;
        make_recent(base, nw, victim, int'(way_rank[base + victim]));
        return ACC_EVICT;
    endfunction

    function automatic t_result predict_outcome(input t_opcode op,
                                                input logic [ADDR_BITS-1:0] addr);
        t_result r;
        t_access_kind kind;
        r = '0;
        if (op != OP_FETCH) begin
            kind = lookup_and_fill(addr);
            if (kind == ACC_HIT) r.hit_count = r.hit_count + 1;
            else r.missed = 1'b1;
            r.evicted = (kind == ACC_EVICT);
            if (op == OP_MODIFY && lookup_and_fill(addr) == ACC_HIT)
                r.hit_count = r.hit_count + 1;
        end
        r.total_hits = hit_total;
        r.total_misses = miss_total;
        r.total_evictions = evict_total;
        return r;
    endfunction

    // Address that lands in a few sets with a dozen tags under the current setting.
    function automatic logic [ADDR_BITS-1:0] fresh_address();
        int sb;
        logic [63:0] a;
        sb = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
        a = (64'($urandom_range(11)) << (int'(cfg_block_bits) + sb))
          | (64'($urandom_range(3) & ((1 << sb) - 1)) << cfg_block_bits)
          | (64'($urandom) & ((64'd1 << cfg_block_bits) - 64'd1));
        return a[ADDR_BITS-1:0];
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_request(input t_opcode op, input logic [ADDR_BITS-1:0] addr,
                                input logic has_exp, input t_result exp);
        t_result p;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= addr;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        p = predict_outcome(op, addr);
        pending_outcomes.push_back(has_exp ? exp : p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SET_BITS:   cfg_set_bits = data[SB_CFG_BITS-1:0];
            CFG_WAYS:       cfg_ways = data[WAYS_CFG_BITS-1:0];
            CFG_BLOCK_BITS: cfg_block_bits = data[BB_CFG_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with no request pending");
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("hit_count", 32'(want.hit_count), 32'(o_m_axis_tdata[1:0]));
                check_field("missed", 32'(want.missed), 32'(o_m_axis_tdata[2]));
                check_field("evicted", 32'(want.evicted), 32'(o_m_axis_tdata[3]));
                check_field("total_hits", want.total_hits, o_m_axis_tdata[35:4]);
                check_field("total_misses", want.total_misses, o_m_axis_tdata[67:36]);
                check_field("total_evictions", want.total_evictions,
                            o_m_axis_tdata[99:68]);
            end
        end
    end

    initial begin : stimulus
        int accesses;
        int sent;
        int r;
        t_opcode op;
        logic [ADDR_BITS-1:0] addr;
        sent = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tuser = OP_FETCH;
        i_s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SET_BITS;
        i_cfg_data = '0;
        cfg_set_bits = RST_SET_BITS;
        cfg_ways = RST_WAYS;
        cfg_block_bits = RST_BLOCK_BITS;
        for (int i = 0; i < NUM_LINES; i++) begin
            way_valid[i] = 1'b0;
            way_tag[i] = '0;
            way_rank[i] = '0;
        end
        hit_total = '0;
        miss_total = '0;
        evict_total = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++) begin
            if (dir_rows[i].is_cfg) begin
                write_reg(dir_rows[i].cfg_index, dir_rows[i].cfg_data);
            end else begin
                send_request(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].has_exp,
                             dir_rows[i].exp);
                sent++;
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_SET_BITS, 5'd0);
                    write_reg(CFG_WAYS, 5'd8);
                    write_reg(CFG_BLOCK_BITS, 5'd0);
                end
                1: begin
                    write_reg(CFG_SET_BITS, 5'd6);
                    write_reg(CFG_WAYS, 5'd1);
                    write_reg(CFG_BLOCK_BITS, 5'd31);
                end
                2: begin
                    write_reg(CFG_SET_BITS, 5'd7);
                    write_reg(CFG_WAYS, 5'd15);
                    write_reg(CFG_BLOCK_BITS, 5'd16);
                end
                3: begin
                    write_reg(CFG_SET_BITS, 5'd1);
                    write_reg(CFG_WAYS, 5'd3);
                    write_reg(CFG_BLOCK_BITS, 5'd2);
                end
                default: begin
                    write_reg(CFG_SET_BITS, 5'($urandom_range(7)));
                    write_reg(CFG_WAYS, 5'($urandom_range(31)));
                    write_reg(CFG_BLOCK_BITS, 5'($urandom_range(31)));
                end
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            foreach (addr_pool[k]) addr_pool[k] = fresh_address();
            accesses = 0;
            while (accesses < ACCESSES_PER_PHASE) begin
                // long receiver hold-off while requests keep coming
                if (phase == 0 && accesses == 30) rx_hold = 200;
                if (phase == 1 && accesses == 50) wait_drained();
                op = t_opcode'($urandom_range(3));
                r = $urandom_range(99);
                if (r < 10) begin
                    addr = $urandom;
                end else if (r < 25) begin
                    addr = fresh_address();
                    addr_pool[$urandom_range(15)] = addr;
                end else begin
                    addr = addr_pool[$urandom_range(15)];
                end
                send_request(op, addr, 1'b0, NO_RESULT);
                sent++;
                if (op != OP_FETCH) accesses++;
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d results never arrived", pending_outcomes.size());
            mismatch_count++;
        end
        $display("Ran %0d requests (%0d directed) over %0d cache settings",
                 sent, NUM_DIR, NUM_PHASES + 4);
        $display("and four handshake modes; cache saw %0d hits, %0d misses, %0d evictions.",
                 hit_total, miss_total, evict_total);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sacl_pkg.sv
rtl/sacl_ram.sv
rtl/sacl_ctrl.sv
rtl/sacl_dp.sv
rtl/set_assoc_cache_lru_tags_top.sv
test/set_assoc_cache_lru_tags_top_test.sv
